// ===== rtl/open_addressing_hash_set_macros.svh =====
// assertion macros for the open-addressing hash set
// no dependencies; included by the files that carry assertions
`ifndef OPEN_ADDRESSING_HASH_SET_MACROS_SVH
`define OPEN_ADDRESSING_HASH_SET_MACROS_SVH
`ifndef SYNTH
`define OAHS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hash set check failed");
`define OAHS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hash set check failed");
`else
`define OAHS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define OAHS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/oahs_pkg.sv =====
// shared constants, codes and threshold tables of the hash set
// no dependencies
package oahs_pkg;

	localparam int MIN_SLOTS = 16;
	localparam int MAX_SLOTS = 1024;
	localparam int KEY_BITS = 32;
	localparam int HASH_BITS = 32;

	localparam int LG_MIN = $clog2(MIN_SLOTS);
	localparam int LG_MAX = $clog2(MAX_SLOTS);
	localparam int IDX_W = LG_MAX;
	localparam int CNT_W = LG_MAX + 1;
	localparam int LG_W = $clog2(LG_MAX + 1);
	localparam int STEP_W = CNT_W + 1;
	localparam int KH_W = KEY_BITS + HASH_BITS;
	localparam int PERT_SHIFT = 5;
	localparam int PROBE_EXTRA = HASH_BITS / 5 + 2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [LG_W-1:0] lg_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DISCARD = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FOUND = 3'd2,
		ST_ABSENT = 3'd3,
		ST_REMOVED = 3'd4,
		ST_FULL = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE = 2'd1,
		MARK_DEAD = 2'd2
	} mark_t;

	typedef cnt_t mark_tab_t [0:LG_MAX];

	function automatic mark_tab_t make_grow_tab();
		mark_tab_t t;
		for (int k = 0; k <= LG_MAX; k++) begin
			t[k] = CNT_W'((2 << k) / 3);
		end
		return t;
	endfunction

	function automatic mark_tab_t make_shrink_tab();
		mark_tab_t t;
		for (int k = 0; k <= LG_MAX; k++) begin
			t[k] = CNT_W'(((2 << k) / 3) / 3);
		end
		return t;
	endfunction

	localparam mark_tab_t GROW_TAB = make_grow_tab();
	localparam mark_tab_t SHRINK_TAB = make_shrink_tab();

endpackage

// ===== rtl/oahs_if.sv =====
// request and response channel interfaces of the hash set
// depends on oahs_pkg
interface oahs_req_if;
	import oahs_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [KEY_BITS-1:0] key;
	logic [HASH_BITS-1:0] key_hash;
	modport source (output valid, command, key, key_hash, input ready);
	modport sink (input valid, command, key, key_hash, output ready);
endinterface

interface oahs_rsp_if;
	import oahs_pkg::*;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [IDX_W-1:0] slot;
	logic [CNT_W-1:0] live_count;
	logic [CNT_W-1:0] table_slots;
	modport source (output valid, status, slot, live_count, table_slots, input ready);
	modport sink (input valid, status, slot, live_count, table_slots, output ready);
endinterface

// ===== rtl/oahs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module oahs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/open_addressing_hash_set.sv =====
// top level of the open-addressing hash set with perturbed probing
// depends on oahs_pkg, oahs_if, oahs_ram and the assertion macro header
//
// channel  dir  word
// req      in   command, key, key_hash
// rsp      out  status, slot, live_count, table_slots
//
// each probe step is a mark/key ram read, then a compare
// a resize sweeps the old table, then reinserts each live word with a probe
// after reset a clearing pass runs over all 1024 words of the mark ram with req.ready low
// one request at a time; the response register lets the next request in while rsp stalls
`include "open_addressing_hash_set_macros.svh"

module open_addressing_hash_set (
	input logic clk,
	input logic arst_n,
	oahs_req_if.sink req,
	oahs_rsp_if.source rsp
);
	import oahs_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_PRD = 12'b000000000100,
		S_PEV = 12'b000000001000,
		S_PRET = 12'b000000010000,
		S_GROW = 12'b000000100000,
		S_SHRINK = 12'b000001000000,
		S_COLLECT = 12'b000010000000,
		S_REINS_RD = 12'b000100000000,
		S_REINS_GO = 12'b001000000000,
		S_FIN = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	typedef enum logic [1:0] {
		C_REQ = 2'd0,
		C_REINS = 2'd1,
		C_SLOT = 2'd2
	} caller_t;

	typedef enum logic [1:0] {
		PR_HIT = 2'd0,
		PR_EMPTY = 2'd1,
		PR_NONE = 2'd2
	} pres_t;

	state_t state_q;
	caller_t caller_q;
	pres_t pres_q;
	logic [1:0] cmd_q;
	logic [KEY_BITS-1:0] key_q, pkey_q;
	logic [HASH_BITS-1:0] hash_q, phash_q, pert_q;
	logic pmatch_q, first_q, cvalid_s1;
	idx_t idx_q, pw_q, caddr_s1, slot_q;
	logic [STEP_W-1:0] steps_q;
	lg_t lg_q, old_lg_q;
	cnt_t live_q, lad_q, smark_q, ci_q, n_q, j_q;
	status_t status_q;
	logic rsp_valid_q;
	logic [2:0] rsp_status_q;
	idx_t rsp_slot_q;
	cnt_t rsp_live_q, rsp_size_q;

	cnt_t size, prev_size;
	idx_t mask, idx_nx, rd_addr;
	logic [HASH_BITS-1:0] pert_nx;
	logic [STEP_W-1:0] limit;
	logic ins_ok;

	logic kh_we, mk_we, tmp_we;
	idx_t kh_waddr, mk_waddr, tmp_waddr;
	logic [KH_W-1:0] kh_wdata, kh_rdata, tmp_wdata, tmp_rdata;
	logic [1:0] mk_wdata, mk_rdata;

	assign size = cnt_t'(1) << lg_q;
	assign prev_size = cnt_t'(1) << old_lg_q;
	assign mask = IDX_W'(size - cnt_t'(1));
	assign limit = STEP_W'(PROBE_EXTRA) + STEP_W'(size);
	assign pert_nx = pert_q >> PERT_SHIFT;
	assign idx_nx = (IDX_W'({idx_q, 2'b00}) + idx_q + pert_nx[IDX_W-1:0] + idx_t'(1)) & mask;
	assign ins_ok = (pres_q == PR_EMPTY) && (live_q < cnt_t'(MAX_SLOTS - 1));
	assign rd_addr = (state_q == S_COLLECT) ? ci_q[IDX_W-1:0] : idx_q;

	always_comb begin
		kh_we = 1'b0;
		kh_waddr = pw_q;
		kh_wdata = {key_q, hash_q};
		mk_we = 1'b0;
		mk_waddr = pw_q;
		mk_wdata = MARK_LIVE;
		tmp_we = 1'b0;
		tmp_waddr = n_q[IDX_W-1:0];
		tmp_wdata = kh_rdata;
		unique case (state_q)
			S_CLEAR: begin
				mk_we = 1'b1;
				mk_waddr = ci_q[IDX_W-1:0];
				mk_wdata = MARK_EMPTY;
			end
			S_COLLECT: begin
				mk_we = cvalid_s1;
				mk_waddr = caddr_s1;
				mk_wdata = MARK_EMPTY;
				tmp_we = cvalid_s1 && (mk_rdata == MARK_LIVE);
			end
			S_PRET: begin
				if (caller_q == C_REQ) begin
					if (cmd_q == CMD_INSERT && ins_ok) begin
						kh_we = 1'b1;
						mk_we = 1'b1;
					end else if (cmd_q == CMD_DISCARD && pres_q == PR_HIT) begin
						mk_we = 1'b1;
						mk_wdata = MARK_DEAD;
					end
				end else if (caller_q == C_REINS && pres_q == PR_EMPTY) begin
					kh_we = 1'b1;
					kh_wdata = {pkey_q, phash_q};
					mk_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	oahs_ram #(.WIDTH(KH_W), .DEPTH(MAX_SLOTS)) u_kh_ram (
		.clk(clk), .we(kh_we), .waddr(kh_waddr), .wdata(kh_wdata),
		.raddr(rd_addr), .rdata(kh_rdata)
	);

	oahs_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_mark_ram (
		.clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.raddr(rd_addr), .rdata(mk_rdata)
	);

	oahs_ram #(.WIDTH(KH_W), .DEPTH(MAX_SLOTS)) u_tmp_ram (
		.clk(clk), .we(tmp_we), .waddr(tmp_waddr), .wdata(tmp_wdata),
		.raddr(j_q[IDX_W-1:0]), .rdata(tmp_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot = rsp_slot_q;
	assign rsp.live_count = rsp_live_q;
	assign rsp.table_slots = rsp_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			caller_q <= C_REQ;
			pres_q <= PR_NONE;
			cmd_q <= '0;
			key_q <= '0;
			hash_q <= '0;
			pkey_q <= '0;
			phash_q <= '0;
			pert_q <= '0;
			pmatch_q <= 1'b0;
			first_q <= 1'b0;
			cvalid_s1 <= 1'b0;
			idx_q <= '0;
			pw_q <= '0;
			caddr_s1 <= '0;
			slot_q <= '0;
			steps_q <= '0;
			lg_q <= lg_t'(LG_MIN);
			old_lg_q <= lg_t'(LG_MIN);
			live_q <= '0;
			lad_q <= '0;
			smark_q <= '0;
			ci_q <= '0;
			n_q <= '0;
			j_q <= '0;
			status_q <= ST_ABSENT;
			rsp_valid_q <= 1'b0;
			rsp_status_q <= '0;
			rsp_slot_q <= '0;
			rsp_live_q <= '0;
			rsp_size_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (ci_q == cnt_t'(MAX_SLOTS - 1)) begin
						ci_q <= '0;
						state_q <= S_IDLE;
					end else begin
						ci_q <= ci_q + cnt_t'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.command;
						key_q <= req.key;
						hash_q <= req.key_hash;
						pkey_q <= req.key;
						phash_q <= req.key_hash;
						idx_q <= req.key_hash[IDX_W-1:0] & mask;
						pert_q <= req.key_hash;
						steps_q <= '0;
						pmatch_q <= 1'b1;
						caller_q <= C_REQ;
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					if (steps_q == limit) begin
						pres_q <= PR_NONE;
						pw_q <= '0;
						state_q <= S_PRET;
					end else begin
						state_q <= S_PEV;
					end
				end
				S_PEV: begin
					if (mk_rdata == MARK_EMPTY) begin
						pres_q <= PR_EMPTY;
						pw_q <= idx_q;
						state_q <= S_PRET;
					end else if (pmatch_q && mk_rdata == MARK_LIVE
							&& kh_rdata[KH_W-1 -: KEY_BITS] == pkey_q) begin
						pres_q <= PR_HIT;
						pw_q <= idx_q;
						state_q <= S_PRET;
					end else begin
						pert_q <= pert_nx;
						idx_q <= idx_nx;
						steps_q <= steps_q + STEP_W'(1);
						state_q <= S_PRD;
					end
				end
				S_PRET: begin
					case (caller_q)
						C_REQ: begin
							case (cmd_q)
								CMD_INSERT: begin
									if (pres_q == PR_HIT) begin
										status_q <= ST_PRESENT;
										slot_q <= pw_q;
										state_q <= S_DONE;
									end else if (ins_ok) begin
										status_q <= ST_ADDED;
										slot_q <= pw_q;
										live_q <= live_q + cnt_t'(1);
										lad_q <= lad_q + cnt_t'(1);
										old_lg_q <= lg_q;
										first_q <= 1'b1;
										state_q <= S_GROW;
									end else begin
										status_q <= ST_FULL;
										slot_q <= '0;
										state_q <= S_DONE;
									end
								end
								CMD_DISCARD: begin
									if (pres_q == PR_HIT) begin
										status_q <= ST_REMOVED;
										slot_q <= pw_q;
										live_q <= live_q - cnt_t'(1);
										old_lg_q <= lg_q;
										state_q <= S_SHRINK;
									end else begin
										status_q <= ST_ABSENT;
										slot_q <= '0;
										state_q <= S_DONE;
									end
								end
								default: begin
									if (pres_q == PR_HIT) begin
										status_q <= ST_FOUND;
										slot_q <= pw_q;
									end else begin
										status_q <= ST_ABSENT;
										slot_q <= '0;
									end
									state_q <= S_DONE;
								end
							endcase
						end
						C_REINS: begin
							j_q <= j_q + cnt_t'(1);
							state_q <= (j_q + cnt_t'(1) == n_q) ? S_FIN : S_REINS_RD;
						end
						C_SLOT: begin
							slot_q <= (pres_q == PR_HIT) ? pw_q : idx_t'(0);
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_GROW: begin
					if (lad_q > GROW_TAB[lg_q] && lg_q < lg_t'(LG_MAX)) begin
						lg_q <= lg_q + lg_t'(1);
						smark_q <= (live_q <= cnt_t'(MIN_SLOTS)) ? cnt_t'(0)
							: SHRINK_TAB[lg_q + lg_t'(1)];
						first_q <= 1'b0;
					end else if (first_q && lad_q <= GROW_TAB[lg_q]) begin
						state_q <= S_DONE;
					end else begin
						ci_q <= '0;
						n_q <= '0;
						cvalid_s1 <= 1'b0;
						state_q <= S_COLLECT;
					end
				end
				S_SHRINK: begin
					if (live_q < smark_q && lg_q > lg_t'(LG_MIN)) begin
						lg_q <= lg_q - lg_t'(1);
						smark_q <= (live_q <= cnt_t'(MIN_SLOTS)) ? cnt_t'(0)
							: SHRINK_TAB[lg_q - lg_t'(1)];
					end else if (lg_q != old_lg_q) begin
						ci_q <= '0;
						n_q <= '0;
						cvalid_s1 <= 1'b0;
						state_q <= S_COLLECT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_COLLECT: begin
					if (ci_q != prev_size) begin
						ci_q <= ci_q + cnt_t'(1);
						caddr_s1 <= ci_q[IDX_W-1:0];
						cvalid_s1 <= 1'b1;
					end else begin
						cvalid_s1 <= 1'b0;
					end
					if (cvalid_s1 && mk_rdata == MARK_LIVE) begin
						n_q <= n_q + cnt_t'(1);
					end
					if (ci_q == prev_size && !cvalid_s1) begin
						j_q <= '0;
						state_q <= (n_q == cnt_t'(0)) ? S_FIN : S_REINS_RD;
					end
				end
				S_REINS_RD: begin
					state_q <= S_REINS_GO;
				end
				S_REINS_GO: begin
					pkey_q <= tmp_rdata[KH_W-1 -: KEY_BITS];
					phash_q <= tmp_rdata[HASH_BITS-1:0];
					idx_q <= tmp_rdata[IDX_W-1:0] & mask;
					pert_q <= tmp_rdata[HASH_BITS-1:0];
					steps_q <= '0;
					pmatch_q <= 1'b0;
					caller_q <= C_REINS;
					state_q <= S_PRD;
				end
				S_FIN: begin
					live_q <= n_q;
					lad_q <= n_q;
					smark_q <= (n_q <= cnt_t'(MIN_SLOTS)) ? cnt_t'(0) : SHRINK_TAB[lg_q];
					if (cmd_q == CMD_INSERT) begin
						pkey_q <= key_q;
						phash_q <= hash_q;
						idx_q <= hash_q[IDX_W-1:0] & mask;
						pert_q <= hash_q;
						steps_q <= '0;
						pmatch_q <= 1'b1;
						caller_q <= C_SLOT;
						state_q <= S_PRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_status_q <= status_q;
						rsp_slot_q <= slot_q;
						rsp_live_q <= live_q;
						rsp_size_q <= size;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`OAHS_ASSERT_IMPL(a_live_le_lad, clk, arst_n, 1'b1, live_q <= lad_q)
	`OAHS_ASSERT_IMPL(a_write_in_table, clk, arst_n, kh_we, kh_waddr <= mask)
	`OAHS_ASSERT_NEXT(a_accept_probes, clk, arst_n, req.valid && req.ready, state_q == S_PRD)
	`OAHS_ASSERT_IMPL(a_size_range, clk, arst_n, 1'b1, lg_q >= lg_t'(LG_MIN) && lg_q <= lg_t'(LG_MAX))

endmodule
